[hdl/pfm_pkg.sv]
// Shared types and constants of the polar field map lookup.
// Used by pfm_front, pfm_back and the top level; depends on nothing.
package pfm_pkg;

  localparam int MaxRadialPoints = 256;
  localparam int MaxAnglePoints  = 256;
  localparam int ValueWidth      = 32;

  localparam int RIdxW      = $clog2(MaxRadialPoints);
  localparam int AIdxW      = $clog2(MaxAnglePoints);
  localparam int AddrW      = RIdxW + AIdxW;
  localparam int TableDepth = MaxRadialPoints * MaxAnglePoints;
  localparam int DataW      = 32;
  localparam int WgtW       = 33;
  localparam int PointsW    = 9;

  localparam int QueueDepth = 16;
  localparam int QCntW      = $clog2(QueueDepth + 1);
  localparam int OutDepth   = 8;
  localparam int OCntW      = $clog2(OutDepth + 1);

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef enum logic [2:0] {
    CFG_RADIAL_MIN      = 3'd0,
    CFG_RADIAL_INV_STEP = 3'd1,
    CFG_ANGLE_INV_STEP  = 3'd2,
    CFG_SECTOR_ANGLE    = 3'd3,
    CFG_RADIAL_POINTS   = 3'd4,
    CFG_ANGLE_POINTS    = 3'd5
  } pfm_cfg_idx_e;

  typedef struct packed {
    logic [31:0]        radial_min;
    logic [31:0]        radial_inv_step;
    logic [31:0]        angle_inv_step;
    logic [24:0]        sector_angle;
    logic [PointsW-1:0] radial_points;
    logic [PointsW-1:0] angle_points;
  } pfm_cfg_t;

  // One request between front and back: a load or a classified query.
  typedef struct packed {
    logic                        is_query;
    logic                        in_map;
    logic                        load_ok;
    logic [3:0][AddrW-1:0]       addr;
    logic [3:0][WgtW-1:0]        wgt;
    logic [2:0][DataW-1:0]       data;
  } pfm_entry_t;

  typedef struct packed {
    logic [ValueWidth-1:0] field;
    logic [ValueWidth-1:0] radial_slope;
    logic [ValueWidth-1:0] angle_slope;
    logic                  in_map;
  } pfm_result_t;

endpackage

[hdl/pfm_fifo.sv]
// Register-based FIFO used for the request queue and the result buffer.
// Depends on nothing; Depth must be a power of two, the writer never overfills.
module pfm_fifo #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = $clog2(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW:0]    wr_q, wr_d, rd_q, rd_d;

  assign wr_d    = wr_q + (PtrW + 1)'(push_i);
  assign rd_d    = rd_q + (PtrW + 1)'(pop_i);
  assign empty_o = (wr_q == rd_q);
  assign data_o  = mem_q[rd_q[PtrW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q[PtrW-1:0]] <= data_i;
  end

endmodule

[hdl/pfm_front.sv]
// Front part: accepts requests, reduces the angle, finds cell, weights, bounds.
// Depends on pfm_pkg; pushes one entry per accepted request into the queue.
module pfm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfm_pkg::pfm_cfg_t  cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [7:0]         load_radial_index_i,
  input  logic [7:0]         load_angle_index_i,
  input  logic [31:0]        load_field_i,
  input  logic [31:0]        load_radial_slope_i,
  input  logic [31:0]        load_angle_slope_i,
  input  logic [31:0]        query_radius_i,
  input  logic [24:0]        query_angle_i,
  input  logic               pop_i,
  output logic               push_o,
  output pfm_pkg::pfm_entry_t push_data_o
);
  import pfm_pkg::*;

  typedef struct packed {
    logic                  cmd;
    logic [7:0]            ri;
    logic [7:0]            ai;
    logic [2:0][DataW-1:0] data;
  } pass_t;

  // Five restoring steps of the angle reduction, highest shift first.
  function automatic logic [24:0] mod_steps(input logic [24:0] r, input logic [24:0] s,
                                            input int top);
    logic [24:0] x;
    x = r;
    for (int k = 0; k < 5; k++) begin
      if ((x >> (top - k)) >= s) x = x - (s << (top - k));
    end
    return x;
  endfunction

  logic             accept;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic [8:0]       v_q;
  pass_t            p_q [9];

  logic [31:0]      rad0_q;
  logic [24:0]      ang_q [6];
  logic [41:0]      rmm1_q, d2_q;
  logic             below_q [2:7];
  logic [57:0]      phi3_q, plo3_q, x4_q;
  logic [RIdxW-1:0] ir_q [5:7];
  logic             irovf_q [5:7];
  logic [15:0]      wr_q [5:7];
  logic [56:0]      px6_q, px7_q;

  logic [PointsW-1:0] rpu_c, apu_c;
  logic [AIdxW-1:0]   it7, it2_7;
  logic               itovf7, inside7;
  logic [RIdxW-1:0]   ir1_7;
  logic [15:0]        wt7;
  logic [16:0]        wr1_q, wr2_q, wt1_q, wt2_q;
  logic               inside8_q;
  logic [3:0][AddrW-1:0] addr8_q;
  logic               load_ok0;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (cnt_q < QCntW'(QueueDepth));
  assign cnt_d      = cnt_q + QCntW'(accept) - QCntW'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      v_q   <= {v_q[7:0], accept};
    end
  end

  assign rpu_c = (int'(cfg_i.radial_points) > MaxRadialPoints) ?
                 PointsW'(MaxRadialPoints) : cfg_i.radial_points;
  assign apu_c = (int'(cfg_i.angle_points) > MaxAnglePoints) ?
                 PointsW'(MaxAnglePoints) : cfg_i.angle_points;

  always_comb begin
    it7     = px7_q[32 +: AIdxW];
    itovf7  = |px7_q[56:32+AIdxW];
    wt7     = px7_q[31:16];
    ir1_7   = ir_q[7] + RIdxW'(1);
    it2_7   = ((PointsW'(it7) + PointsW'(1)) >= apu_c) ? '0 : it7 + AIdxW'(1);
    inside7 = !below_q[7] && (rpu_c >= PointsW'(2)) && !irovf_q[7]
              && ((PointsW'(ir_q[7]) + PointsW'(1)) < rpu_c)
              && !itovf7 && (PointsW'(it7) < apu_c);
  end

  assign load_ok0 = (int'(p_q[0].ri) < MaxRadialPoints) && (int'(p_q[0].ai) < MaxAnglePoints);

  always_ff @(posedge clk_i) begin
    // Hold the request.
    p_q[0]  <= '{cmd: command_i, ri: load_radial_index_i, ai: load_angle_index_i,
                 data: {load_field_i, load_radial_slope_i, load_angle_slope_i}};
    rad0_q  <= query_radius_i;
    ang_q[0] <= query_angle_i;
    for (int s = 1; s < 9; s++) p_q[s] <= p_q[s-1];

    // Radius to millimetres, offset, scale.
    rmm1_q     <= 42'(rad0_q) * 42'd1000;
    below_q[2] <= rmm1_q < 42'(cfg_i.radial_min);
    d2_q       <= rmm1_q - 42'(cfg_i.radial_min);
    phi3_q     <= 58'(d2_q) * 58'(cfg_i.radial_inv_step[31:16]);
    plo3_q     <= 58'(d2_q) * 58'(cfg_i.radial_inv_step[15:0]);
    x4_q       <= phi3_q + (plo3_q >> 16);
    for (int s = 3; s < 8; s++) below_q[s] <= below_q[s-1];

    ir_q[5]    <= x4_q[16 +: RIdxW];
    irovf_q[5] <= |x4_q[57:16+RIdxW];
    wr_q[5]    <= x4_q[15:0];
    for (int s = 6; s < 8; s++) begin
      ir_q[s]    <= ir_q[s-1];
      irovf_q[s] <= irovf_q[s-1];
      wr_q[s]    <= wr_q[s-1];
    end

    // Angle modulo sector angle, five bits a stage; a zero sector leaves it.
    ang_q[1] <= mod_steps(ang_q[0], cfg_i.sector_angle, 24);
    ang_q[2] <= mod_steps(ang_q[1], cfg_i.sector_angle, 19);
    ang_q[3] <= mod_steps(ang_q[2], cfg_i.sector_angle, 14);
    ang_q[4] <= mod_steps(ang_q[3], cfg_i.sector_angle, 9);
    ang_q[5] <= mod_steps(ang_q[4], cfg_i.sector_angle, 4);
    px6_q    <= 57'(ang_q[5]) * 57'(cfg_i.angle_inv_step);
    px7_q    <= px6_q;

    // Classify and form corner addresses and 1-D weights.
    wr1_q      <= 17'(wr_q[7]);
    wr2_q      <= 17'h10000 - 17'(wr_q[7]);
    wt1_q      <= 17'(wt7);
    wt2_q      <= 17'h10000 - 17'(wt7);
    inside8_q  <= inside7;
    if (p_q[7].cmd == CmdQuery) begin
      addr8_q <= {{ir1_7, it2_7}, {ir_q[7], it2_7}, {ir1_7, it7}, {ir_q[7], it7}};
    end else begin
      addr8_q <= {4{p_q[7].ri[RIdxW-1:0], p_q[7].ai[AIdxW-1:0]}};
    end
  end

  // Carry the load range check down with the request.
  logic load_ok_q [1:8];
  always_ff @(posedge clk_i) begin
    load_ok_q[1] <= load_ok0;
    for (int s = 2; s < 9; s++) load_ok_q[s] <= load_ok_q[s-1];
  end

  logic [33:0] w11, w21, w12, w22;
  assign w11 = 34'(wr2_q) * 34'(wt2_q);
  assign w21 = 34'(wr1_q) * 34'(wt2_q);
  assign w12 = 34'(wr2_q) * 34'(wt1_q);
  assign w22 = 34'(wr1_q) * 34'(wt1_q);

  assign push_o = v_q[8];
  always_comb begin
    push_data_o.is_query = (p_q[8].cmd == CmdQuery);
    push_data_o.in_map   = inside8_q;
    push_data_o.load_ok  = load_ok_q[8];
    push_data_o.addr     = addr8_q;
    push_data_o.wgt      = {WgtW'(w22), WgtW'(w12), WgtW'(w21), WgtW'(w11)};
    push_data_o.data     = p_q[8].data;
  end

endmodule

[hdl/pfm_back.sv]
// Back part: applies loads to the tables, reads four corners, blends, saturates.
// Depends on pfm_pkg; pops the request queue and pushes the result buffer.
module pfm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  pfm_pkg::pfm_entry_t q_data_i,
  output logic                q_pop_o,
  output logic                res_push_o,
  output pfm_pkg::pfm_result_t res_data_o,
  input  logic                res_pop_i
);
  import pfm_pkg::*;

  localparam logic signed [62:0] SatHi = (63'sd1 <<< (ValueWidth - 1)) - 63'sd1;
  localparam logic signed [62:0] SatLo = -SatHi - 63'sd1;

  function automatic logic [ValueWidth-1:0] sat(input logic signed [62:0] v);
    logic signed [62:0] x;
    x = v;
    if (x > SatHi) x = SatHi;
    if (x < SatLo) x = SatLo;
    return x[ValueWidth-1:0];
  endfunction

  logic             qry;
  logic [OCntW-1:0] cnt_q, cnt_d;
  logic             v1_q, v2_q, v3_q, v4_q;
  logic             in1_q, in2_q, in3_q, in4_q;
  logic [WgtW-1:0]  wgt1_q [4];
  logic [3*DataW-1:0] rd_q [4];
  logic signed [65:0] prod2_q [3][4];
  logic signed [51:0] sum3_q [3];
  logic signed [51:0] f4_q, as4_q;
  logic signed [62:0] rs4_q;
  logic               wr;

  assign q_pop_o = !q_empty_i && (cnt_q < OCntW'(OutDepth));
  assign qry     = q_pop_o && q_data_i.is_query;
  assign wr      = q_pop_o && !q_data_i.is_query && q_data_i.load_ok;
  assign cnt_d   = cnt_q + OCntW'(qry) - OCntW'(res_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      v1_q  <= qry;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
    end
  end

  // One table copy per corner; each row holds field, radial and angular slope.
  for (genvar c = 0; c < 4; c++) begin : g_bank
    logic [3*DataW-1:0] mem [TableDepth];
    always_ff @(posedge clk_i) begin
      if (wr) mem[q_data_i.addr[0]] <= q_data_i.data;
      rd_q[c] <= mem[q_data_i.addr[c]];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) wgt1_q[c] <= q_data_i.wgt[c];
    in1_q <= q_data_i.in_map;
    in2_q <= in1_q;
    in3_q <= in2_q;
    in4_q <= in3_q;
    for (int t = 0; t < 3; t++) begin
      for (int c = 0; c < 4; c++) begin
        prod2_q[t][c] <= 66'($signed(rd_q[c][(2-t)*DataW +: DataW]))
                         * $signed({33'd0, wgt1_q[c]});
      end
      sum3_q[t] <= 52'(prod2_q[t][0] >>> 16) + 52'(prod2_q[t][1] >>> 16)
                 + 52'(prod2_q[t][2] >>> 16) + 52'(prod2_q[t][3] >>> 16);
    end
    f4_q  <= sum3_q[0];
    rs4_q <= 63'(sum3_q[1]) * 63'sd1000;
    as4_q <= sum3_q[2];
  end

  assign res_push_o = v4_q;
  always_comb begin
    res_data_o.in_map = in4_q;
    if (in4_q) begin
      res_data_o.field        = sat(63'(f4_q >>> 16));
      res_data_o.radial_slope = sat(rs4_q >>> 16);
      res_data_o.angle_slope  = sat(63'(as4_q >>> 16));
    end else begin
      res_data_o.field        = '0;
      res_data_o.radial_slope = '0;
      res_data_o.angle_slope  = '0;
    end
  end

endmodule

[hdl/polar_field_map_bilinear_lookup.sv]
// Top level of the polar field map lookup: config registers, front, queue, back.
// Depends on pfm_pkg, pfm_fifo, pfm_front and pfm_back.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one request per handshake:
//    command_i low loads one grid entry into all three tables, high queries.
//  - Output channel (out_valid_o/out_ready_i) returns one result per query,
//    none per load, in request order.
//  - Config writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at once;
//    issue them only while no request is in flight.
//  - Throughput: one request per cycle, sustained while in_ready_o stays high.
//    The path from input to output handshake runs through nine front stages
//    (radius scale, five-stage angle reduction, cell and weight), the queue,
//    the table read, three blend stages and the result buffer.
//  - A 16-entry queue separates front and back; the front takes requests
//    while queue credit remains. An 8-entry result buffer lets the back run
//    on while the receiver stalls; when it fills, the back holds and the
//    queue fills behind it, then in_ready_o drops.
//  - Reset clears control and sets config to its defaults; table contents
//    stay undefined until loaded. No clearing pass is run.
module polar_field_map_bilinear_lookup (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  load_radial_index_i,
  input  logic [7:0]  load_angle_index_i,
  input  logic [31:0] load_field_i,
  input  logic [31:0] load_radial_slope_i,
  input  logic [31:0] load_angle_slope_i,
  input  logic [31:0] query_radius_i,
  input  logic [24:0] query_angle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [pfm_pkg::ValueWidth-1:0] field_value_o,
  output logic [pfm_pkg::ValueWidth-1:0] field_radial_slope_o,
  output logic [pfm_pkg::ValueWidth-1:0] field_angle_slope_o,
  output logic        inside_map_o
);
  import pfm_pkg::*;

  pfm_cfg_t    cfg_q;
  logic        push, pop, q_empty;
  pfm_entry_t  push_data, q_data;
  logic        res_push, res_pop, res_empty;
  pfm_result_t res_in, res_out;

  // Config registers; writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radial_min      <= 32'd0;
      cfg_q.radial_inv_step <= 32'd65536;
      cfg_q.angle_inv_step  <= 32'd65536;
      cfg_q.sector_angle    <= 25'd23592960;
      cfg_q.radial_points   <= PointsW'(256);
      cfg_q.angle_points    <= PointsW'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RADIAL_MIN:      cfg_q.radial_min      <= cfg_data_i;
        CFG_RADIAL_INV_STEP: cfg_q.radial_inv_step <= cfg_data_i;
        CFG_ANGLE_INV_STEP:  cfg_q.angle_inv_step  <= cfg_data_i;
        CFG_SECTOR_ANGLE:    cfg_q.sector_angle    <= cfg_data_i[24:0];
        CFG_RADIAL_POINTS:   cfg_q.radial_points   <= cfg_data_i[PointsW-1:0];
        CFG_ANGLE_POINTS:    cfg_q.angle_points    <= cfg_data_i[PointsW-1:0];
        default: ;
      endcase
    end
  end

  pfm_front u_front (
    .clk_i, .rst_ni,
    .cfg_i               (cfg_q),
    .in_valid_i, .in_ready_o,
    .command_i, .load_radial_index_i, .load_angle_index_i,
    .load_field_i, .load_radial_slope_i, .load_angle_slope_i,
    .query_radius_i, .query_angle_i,
    .pop_i               (pop),
    .push_o              (push),
    .push_data_o         (push_data)
  );

  pfm_fifo #(.Width($bits(pfm_entry_t)), .Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .data_o  (q_data),
    .empty_o (q_empty)
  );

  pfm_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i  (q_empty),
    .q_data_i   (q_data),
    .q_pop_o    (pop),
    .res_push_o (res_push),
    .res_data_o (res_in),
    .res_pop_i  (res_pop)
  );

  pfm_fifo #(.Width($bits(pfm_result_t)), .Depth(OutDepth)) u_out (
    .clk_i, .rst_ni,
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (res_pop),
    .data_o  (res_out),
    .empty_o (res_empty)
  );

  // Advance the result buffer on each output handshake.
  assign out_valid_o          = !res_empty;
  assign res_pop              = out_valid_o && out_ready_i;
  assign field_value_o        = res_out.field;
  assign field_radial_slope_o = res_out.radial_slope;
  assign field_angle_slope_o  = res_out.angle_slope;
  assign inside_map_o         = res_out.in_map;

endmodule

[sim/polar_field_map_bilinear_lookup_tb.sv]
// Self-checking testbench of the polar field map lookup: directed table, then random phases.
// Depends on pfm_pkg and the polar_field_map_bilinear_lookup RTL only.
module polar_field_map_bilinear_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfm_pkg::*;

  typedef struct packed {
    logic [31:0] field;
    logic [31:0] rslope;
    logic [31:0] aslope;
    logic        in_map;
  } lookup_res_t;

  // One request: a table load or a position query, with an optional fixed answer.
  typedef struct packed {
    logic        cmd;
    logic [7:0]  ri;
    logic [7:0]  ai;
    logic [31:0] fld;
    logic [31:0] rsl;
    logic [31:0] asl;
    logic [31:0] rad;
    logic [24:0] ang;
    logic        fixed;
    lookup_res_t res;
  } lookup_req_t;

  localparam int          NumPhases  = 12;
  localparam int          PhaseItems = 120;
  localparam int          SettleCyc  = 40;
  localparam logic [24:0] AngleTop   = 25'd23592959;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        command_i = CmdLoad;
  logic [7:0]  load_radial_index_i = '0;
  logic [7:0]  load_angle_index_i = '0;
  logic [31:0] load_field_i = '0;
  logic [31:0] load_radial_slope_i = '0;
  logic [31:0] load_angle_slope_i = '0;
  logic [31:0] query_radius_i = '0;
  logic [24:0] query_angle_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [ValueWidth-1:0] field_value_o;
  logic [ValueWidth-1:0] field_radial_slope_o;
  logic [ValueWidth-1:0] field_angle_slope_o;
  logic        inside_map_o;

  // Fixed answer riding along with the request on the bus.
  logic        cur_fixed = 1'b0;
  lookup_res_t cur_res = '0;

  polar_field_map_bilinear_lookup uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copy, tables as seen at the input, and the plan of written cells.
  longint unsigned rmin_q, rinv_q, ainv_q, sector_q, rpu_q, apu_q;
  int  fld_mem [TableDepth];
  int  rsl_mem [TableDepth];
  int  asl_mem [TableDepth];
  bit  planned [TableDepth];

  lookup_req_t stim_q [$];
  lookup_res_t expect_q [$];
  int  pushed_cnt = 0;
  int  accepted_cnt = 0;
  int  errors = 0;
  bit  stim_done = 1'b0;
  logic hold_off = 1'b0;

  // Find the grid cell and weights of a query; ok is low when it falls outside.
  function automatic void locate(input logic [31:0] rad, input logic [24:0] ang,
                                 output bit ok, output logic [7:0] ir, it, it2,
                                 output longint wr1, wt1);
    longint unsigned mm, d, x, am, px, irl, itl, rpu, apu;
    ok = 1'b0; ir = '0; it = '0; it2 = '0; wr1 = 0; wt1 = 0;
    rpu = (rpu_q > MaxRadialPoints) ? MaxRadialPoints : rpu_q;
    apu = (apu_q > MaxAnglePoints) ? MaxAnglePoints : apu_q;
    mm = 64'(rad) * 1000;
    if (mm < rmin_q) return;
    d = mm - rmin_q;
    x = d * (rinv_q >> 16) + ((d * (rinv_q & 64'hffff)) >> 16);
    irl = x >> 16;
    wr1 = longint'(x & 64'hffff);
    am = 64'(ang);
    if (sector_q != 0) am = am % sector_q;
    px = am * ainv_q;
    itl = px >> 32;
    wt1 = longint'((px >> 16) & 64'hffff);
    if (rpu < 2 || irl + 1 >= rpu || itl >= apu) return;
    ok = 1'b1;
    ir = irl[7:0];
    it = itl[7:0];
    it2 = (itl + 1 >= apu) ? 8'd0 : 8'(itl + 1);
  endfunction

  function automatic longint mix4(int v0, v1, v2, v3, longint w0, w1, w2, w3);
    return ((longint'(v0) * w0) >>> 16) + ((longint'(v1) * w1) >>> 16) +
           ((longint'(v2) * w2) >>> 16) + ((longint'(v3) * w3) >>> 16);
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sh7fffffff) return 32'h7fffffff;
    if (v < -64'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  // Blend the four corners of all three tables for one query.
  function automatic lookup_res_t field_at(logic [31:0] rad, logic [24:0] ang);
    lookup_res_t r;
    bit ok;
    logic [7:0] ir, it, it2;
    longint wr1, wt1, w11, w21, w12, w22;
    int a, b, c, e;
    r = '0;
    locate(rad, ang, ok, ir, it, it2, wr1, wt1);
    if (!ok) return r;
    w11 = (65536 - wr1) * (65536 - wt1);
    w21 = wr1 * (65536 - wt1);
    w12 = (65536 - wr1) * wt1;
    w22 = wr1 * wt1;
    a = {ir, it};
    b = {ir + 8'd1, it};
    c = {ir, it2};
    e = {ir + 8'd1, it2};
    r.field  = clip32(mix4(fld_mem[a], fld_mem[b], fld_mem[c], fld_mem[e],
                           w11, w21, w12, w22) >>> 16);
    r.rslope = clip32((mix4(rsl_mem[a], rsl_mem[b], rsl_mem[c], rsl_mem[e],
                            w11, w21, w12, w22) * 1000) >>> 16);
    r.aslope = clip32(mix4(asl_mem[a], asl_mem[b], asl_mem[c], asl_mem[e],
                           w11, w21, w12, w22) >>> 16);
    r.in_map = 1'b1;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'hffffffff;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic issue(lookup_req_t q);
    if (q.cmd == CmdLoad) planned[{q.ri, q.ai}] = 1'b1;
    stim_q.push_back(q);
    pushed_cnt++;
  endtask

  task automatic issue_load(logic [7:0] ri, ai);
    lookup_req_t q;
    q = '0;
    q.cmd = CmdLoad; q.ri = ri; q.ai = ai;
    q.fld = rand_word(); q.rsl = rand_word(); q.asl = rand_word();
    q.rad = $urandom; q.ang = 25'($urandom);
    issue(q);
  endtask

  // Query aimed inside the grid most of the time; fill any unwritten corner first.
  task automatic issue_query(bit aimed);
    lookup_req_t q;
    longint unsigned dmax, d, r, amax, am, rpu, apu;
    bit ok;
    logic [7:0] ir, it, it2;
    longint wr1, wt1;
    q = '0;
    q.cmd = CmdQuery;
    q.fld = $urandom; q.rsl = $urandom; q.asl = $urandom;
    q.ri = 8'($urandom); q.ai = 8'($urandom);
    rpu = (rpu_q > MaxRadialPoints) ? MaxRadialPoints : rpu_q;
    apu = (apu_q > MaxAnglePoints) ? MaxAnglePoints : apu_q;
    if (aimed) begin
      dmax = (rinv_q == 0) ? 64'h400_0000_0000 : ((rpu - 1) << 32) / rinv_q;
      d = {$urandom, $urandom} % (dmax + dmax / 16 + 2);
      r = (rmin_q + d + 999) / 1000;
      if ($urandom_range(0, 19) == 0 && rmin_q >= 4000)
        r = rmin_q / 1000 - $urandom_range(0, 3);
      if (r > 64'hffffffff) r = 64'hffffffff;
      amax = (ainv_q == 0) ? sector_q - 1 : (apu << 32) / ainv_q;
      amax = amax + amax / 16 + 1;
      if (amax > sector_q - 1) amax = sector_q - 1;
      am = 64'($urandom) % (amax + 1);
      am += sector_q * $urandom_range(0, int'((AngleTop - am) / sector_q));
      q.rad = r[31:0];
      q.ang = am[24:0];
    end else begin
      q.rad = $urandom;
      q.ang = 25'($urandom_range(0, AngleTop));
    end
    locate(q.rad, q.ang, ok, ir, it, it2, wr1, wt1);
    if (ok) begin
      if (!planned[{ir, it}]) issue_load(ir, it);
      if (!planned[{ir + 8'd1, it}]) issue_load(ir + 8'd1, it);
      if (!planned[{ir, it2}]) issue_load(ir, it2);
      if (!planned[{ir + 8'd1, it2}]) issue_load(ir + 8'd1, it2);
    end
    issue(q);
  endtask

  task automatic write_reg(pfm_cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_RADIAL_MIN:      rmin_q = val;
      CFG_RADIAL_INV_STEP: rinv_q = val;
      CFG_ANGLE_INV_STEP:  ainv_q = val;
      CFG_SECTOR_ANGLE:    sector_q = val[24:0];
      CFG_RADIAL_POINTS:   rpu_q = val[8:0];
      CFG_ANGLE_POINTS:    apu_q = val[8:0];
      default: ;
    endcase
  endtask

  // Hold until every request is taken and answered, then let loads drain.
  task automatic wait_idle();
    while (accepted_cnt != pushed_cnt || expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // Directed table at the reset settings: 1 mm radial step, 1 degree angular step.
  lookup_req_t dir_rows [16];
  localparam lookup_res_t Outside = '0;

  initial begin
    dir_rows = '{
      '{CmdLoad, 8'd0, 8'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'd0, 25'd0, 1'b0, Outside},
      '{CmdLoad, 8'd1, 8'd0, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'd0, 25'd0, 1'b0, Outside},
      '{CmdLoad, 8'd0, 8'd1, 32'h00010000, 32'hffff0000, 32'h12345678, 32'd0, 25'd0, 1'b0, Outside},
      '{CmdLoad, 8'd1, 8'd1, 32'hffffffff, 32'h00000001, 32'hedcba987, 32'd0, 25'd0, 1'b0, Outside},
      '{CmdQuery, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 25'd0, 1'b0, Outside},
      '{CmdQuery, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd33, 25'd32768, 1'b0, Outside},
      '{CmdLoad, 8'd254, 8'd255, 32'h00123456, 32'h7fffffff, 32'h80000001, 32'd0, 25'd0,
        1'b0, Outside},
      '{CmdLoad, 8'd255, 8'd255, 32'hfff00000, 32'h00400000, 32'h7ffffffe, 32'd0, 25'd0,
        1'b0, Outside},
      '{CmdLoad, 8'd254, 8'd0, 32'h55555555, 32'haaaaaaaa, 32'h0000ffff, 32'd0, 25'd0,
        1'b0, Outside},
      '{CmdLoad, 8'd255, 8'd0, 32'haaaaaaaa, 32'h55555555, 32'hffff0000, 32'd0, 25'd0,
        1'b0, Outside},
      // upper angular corner wraps to column 0
      '{CmdQuery, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd16647, 25'd16744448, 1'b0, Outside},
      // past the last radial cell
      '{CmdQuery, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd16712, 25'd0, 1'b1, Outside},
      // past the last angular column
      '{CmdQuery, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 25'd19660800, 1'b1, Outside},
      '{CmdQuery, 8'hff, 8'hff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
        25'h167ffff, 1'b1, Outside},
      '{CmdQuery, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 25'h167ffff, 1'b1, Outside},
      '{CmdLoad, 8'd255, 8'd255, 32'd0, 32'd0, 32'd0, 32'd0, 25'd0, 1'b0, Outside}
    };
  end

  // Main sequence: reset, directed table, then random phases between config writes.
  initial begin
    rmin_q = 0; rinv_q = 65536; ainv_q = 65536;
    sector_q = 23592960; rpu_q = 256; apu_q = 256;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_rows[i]) issue(dir_rows[i]);
    wait_idle();
    for (int p = 0; p < NumPhases; p++) begin
      write_reg(CFG_RADIAL_MIN, (p == 2) ? 32'hffffffff : (p % 3 == 0) ? 32'd0 : $urandom);
      write_reg(CFG_RADIAL_INV_STEP, (p == 3) ? 32'd0 : (p == 4) ? 32'hffffffff :
                (p == 5) ? $urandom : $urandom_range(1 << 12, 1 << 20));
      write_reg(CFG_ANGLE_INV_STEP, (p == 5) ? 32'd0 : (p == 6) ? 32'hffffffff :
                $urandom_range(1 << 12, 1 << 19));
      write_reg(CFG_SECTOR_ANGLE, (p == 1) ? 32'd65536 : (p == 2) ? 32'd23592960 :
                $urandom_range(65536, 23592960));
      write_reg(CFG_RADIAL_POINTS, (p == 1) ? 32'd2 : (p == 4) ? 32'd256 :
                (p % 2 == 1) ? $urandom_range(2, 12) : $urandom_range(2, 256));
      write_reg(CFG_ANGLE_POINTS, (p == 1) ? 32'd1 : (p == 6) ? 32'd256 :
                (p % 2 == 1) ? $urandom_range(1, 12) : $urandom_range(1, 256));
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      begin
        int goal;
        goal = pushed_cnt + PhaseItems;
        while (pushed_cnt < goal) begin
          case ($urandom_range(0, 9))
            0, 1, 2: issue_load(8'($urandom), 8'($urandom));
            3:       issue_query(1'b0);
            default: issue_query(1'b1);
          endcase
        end
      end
      wait_idle();
    end
    stim_done = 1'b1;
    wait_idle();
    if (errors == 0) begin
      $display("PASS polar_field_map_bilinear_lookup");
    end else begin
      $display("FAIL polar_field_map_bilinear_lookup");
    end
    $finish;
  end

  // Sender: draw a gap per request, with runs of back-to-back requests.
  initial begin
    lookup_req_t q;
    int gap;
    bit burst;
    burst = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      while (stim_q.size() == 0 && !stim_done) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      if (stim_q.size() == 0) break;
      q = stim_q.pop_front();
      if ($urandom_range(0, 39) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      command_i <= q.cmd;
      load_radial_index_i <= q.ri;
      load_angle_index_i <= q.ai;
      load_field_i <= q.fld;
      load_radial_slope_i <= q.rsl;
      load_angle_slope_i <= q.asl;
      query_radius_i <= q.rad;
      query_angle_i <= q.ang;
      cur_fixed <= q.fixed;
      cur_res <= q.res;
      do @(posedge clk_i); while (!in_ready_o);
    end
  end

  // Receiver: stall per result, and hold off completely while hold_off is set.
  initial begin
    int stall;
    bit burst;
    burst = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) burst = !burst;
      stall = burst ? 0 : $urandom_range(0, 13);
      if (stall > 0 || hold_off) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
        while (hold_off) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Long receiver stall mid-run so the result buffer and queue fill up.
  initial begin
    wait (accepted_cnt >= 400);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Advance the model on each accepted request.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      accepted_cnt++;
      if (command_i == CmdLoad) begin
        fld_mem[{load_radial_index_i, load_angle_index_i}] = load_field_i;
        rsl_mem[{load_radial_index_i, load_angle_index_i}] = load_radial_slope_i;
        asl_mem[{load_radial_index_i, load_angle_index_i}] = load_angle_slope_i;
      end else begin
        expect_q.push_back(cur_fixed ? cur_res : field_at(query_radius_i, query_angle_i));
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    lookup_res_t want, got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{field_value_o, field_radial_slope_o, field_angle_slope_o, inside_map_o};
      if (expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = expect_q.pop_front();
        if (got.field !== want.field) begin
          errors++;
          $display("%0t: field_value exp %h got %h", $time, want.field, got.field);
        end
        if (got.rslope !== want.rslope) begin
          errors++;
          $display("%0t: field_radial_slope exp %h got %h", $time, want.rslope, got.rslope);
        end
        if (got.aslope !== want.aslope) begin
          errors++;
          $display("%0t: field_angle_slope exp %h got %h", $time, want.aslope, got.aslope);
        end
        if (got.in_map !== want.in_map) begin
          errors++;
          $display("%0t: inside_map exp %b got %b", $time, want.in_map, got.in_map);
        end
      end
    end
  end

  // Drop the run if it hangs.
  initial begin
    #20_000_000;
    $display("FAIL polar_field_map_bilinear_lookup");
    $finish;
  end

endmodule

[sim.f]
hdl/pfm_pkg.sv
hdl/pfm_fifo.sv
hdl/pfm_front.sv
hdl/pfm_back.sv
hdl/polar_field_map_bilinear_lookup.sv
sim/polar_field_map_bilinear_lookup_tb.sv
